@@ src/bbo_pkg.sv @@
// Package for the bidirectional beam occupancy counter.
// Holds widths, reset values, tracker phase codes and the result type.
// No dependencies; the modules, the checker and the testbench import it.
package bbo_pkg;

  // Default widths, handed to the top-level parameters
  localparam int BinWidthDef   = 16;
  localparam int CountWidthDef = 16;

  // Fixed widths of the register and the reported fields
  localparam int ThreshWidth   = 32;
  localparam int OutCountWidth = 16;
  localparam int PhaseWidth    = 4;

  localparam logic [ThreshWidth-1:0] ThreshReset = 32'd1048576;

  // Tracker phase codes: start, entry path L0..L3, exit path R0..R3
  localparam logic [PhaseWidth-1:0] PH_START = 4'd0;
  localparam logic [PhaseWidth-1:0] PH_L0    = 4'd1;
  localparam logic [PhaseWidth-1:0] PH_L1    = 4'd2;
  localparam logic [PhaseWidth-1:0] PH_L2    = 4'd3;
  localparam logic [PhaseWidth-1:0] PH_L3    = 4'd4;
  localparam logic [PhaseWidth-1:0] PH_R0    = 4'd5;
  localparam logic [PhaseWidth-1:0] PH_R1    = 4'd6;
  localparam logic [PhaseWidth-1:0] PH_R2    = 4'd7;
  localparam logic [PhaseWidth-1:0] PH_R3    = 4'd8;

  // One result item as it leaves the tracker
  typedef struct packed {
    logic [OutCountWidth-1:0] occupant_count;
    logic                     entry_event;
    logic                     exit_event;
    logic                     empty_exit;
    logic                     low_source_hidden;
    logic                     high_source_hidden;
    logic [PhaseWidth-1:0]    tracker_phase;
  } bbo_result_t;

endpackage

@@ src/bbo_in_if.sv @@
// Input channel: one analysis frame with two spectrum bins per item.
// Valid/ready handshake; depends on nothing but its width parameter.
interface bbo_in_if #(
  parameter int BIN_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [BIN_WIDTH-1:0] low_bin_real;
  logic signed [BIN_WIDTH-1:0] low_bin_imag;
  logic signed [BIN_WIDTH-1:0] high_bin_real;
  logic signed [BIN_WIDTH-1:0] high_bin_imag;

  modport source (
    output valid, low_bin_real, low_bin_imag, high_bin_real, high_bin_imag,
    input  ready
  );
  modport sink (
    input  valid, low_bin_real, low_bin_imag, high_bin_real, high_bin_imag,
    output ready
  );
endinterface

@@ src/bbo_out_if.sv @@
// Output channel: one result item per accepted frame.
// Valid/ready handshake; field widths are fixed by the result format.
interface bbo_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] occupant_count;
  logic        entry_event;
  logic        exit_event;
  logic        empty_exit;
  logic        low_source_hidden;
  logic        high_source_hidden;
  logic [3:0]  tracker_phase;

  modport source (
    output valid, occupant_count, entry_event, exit_event, empty_exit,
           low_source_hidden, high_source_hidden, tracker_phase,
    input  ready
  );
  modport sink (
    input  valid, occupant_count, entry_event, exit_event, empty_exit,
           low_source_hidden, high_source_hidden, tracker_phase,
    output ready
  );
endinterface

@@ src/bidirectional_beam_occupancy_counter.sv @@
// Bidirectional beam occupancy counter. Each accepted frame yields one result
// item: both beams are judged hidden or visible by squared bin magnitude
// against the threshold register, the tracker advances, and the occupancy
// count moves on a completed entry or exit. The block takes one frame per
// cycle while the result side takes items; a frame passes an input register
// and then a result register before its result is offered. Both registers
// move at once while the result side takes items, so a stalled result holds
// at most one frame behind it. Write the threshold only while no frame is in
// flight.
module bidirectional_beam_occupancy_counter #(
  parameter int BIN_WIDTH   = bbo_pkg::BinWidthDef,
  parameter int COUNT_WIDTH = bbo_pkg::CountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bbo_pkg::ThreshWidth-1:0] cfg_wdata_i,
  bbo_in_if.sink                          in_i,
  bbo_out_if.source                       out_o
);
  import bbo_pkg::*;

  logic [ThreshWidth-1:0]      thresh_q;
  logic                        in_valid_q;
  logic signed [BIN_WIDTH-1:0] low_re_q, low_im_q, high_re_q, high_im_q;
  logic                        out_valid_q;
  bbo_result_t                 out_q;
  bbo_result_t                 result;
  logic                        advance;
  logic                        low_hidden, high_hidden;

  // Move an item to the result register when it is free or being taken
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      low_re_q  <= in_i.low_bin_real;
      low_im_q  <= in_i.low_bin_imag;
      high_re_q <= in_i.high_bin_real;
      high_im_q <= in_i.high_bin_imag;
    end
  end

  // Judge both beams
  bbo_beam_detect #(.BIN_WIDTH(BIN_WIDTH)) u_low_detect (
    .re_i     (low_re_q),
    .im_i     (low_im_q),
    .thresh_i (thresh_q),
    .hidden_o (low_hidden)
  );

  bbo_beam_detect #(.BIN_WIDTH(BIN_WIDTH)) u_high_detect (
    .re_i     (high_re_q),
    .im_i     (high_im_q),
    .thresh_i (thresh_q),
    .hidden_o (high_hidden)
  );

  // Advance the tracker and the count
  bbo_tracker #(.COUNT_WIDTH(COUNT_WIDTH)) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .low_hidden_i  (low_hidden),
    .high_hidden_i (high_hidden),
    .result_o      (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  // Drive the result channel
  assign out_o.valid              = out_valid_q;
  assign out_o.occupant_count     = out_q.occupant_count;
  assign out_o.entry_event        = out_q.entry_event;
  assign out_o.exit_event         = out_q.exit_event;
  assign out_o.empty_exit         = out_q.empty_exit;
  assign out_o.low_source_hidden  = out_q.low_source_hidden;
  assign out_o.high_source_hidden = out_q.high_source_hidden;
  assign out_o.tracker_phase      = out_q.tracker_phase;

endmodule

@@ src/bbo_beam_detect.sv @@
// Beam detector for one source: squared bin magnitude against the threshold.
// Uses bbo_pkg for the threshold width.
module bbo_beam_detect #(
  parameter int BIN_WIDTH = 16
) (
  input  logic signed [BIN_WIDTH-1:0]            re_i,
  input  logic signed [BIN_WIDTH-1:0]            im_i,
  input  logic        [bbo_pkg::ThreshWidth-1:0] thresh_i,
  output logic                                   hidden_o
);
  import bbo_pkg::*;

  localparam int SqWidth  = 2 * BIN_WIDTH;
  localparam int CmpWidth = (SqWidth > ThreshWidth) ? SqWidth : ThreshWidth;

  logic signed [SqWidth-1:0]  re_sq;
  logic signed [SqWidth-1:0]  im_sq;
  logic        [SqWidth-1:0]  mag_sq;
  logic        [CmpWidth-1:0] mag_ext;
  logic        [CmpWidth-1:0] thresh_ext;

  // Square both parts; each square is nonnegative and the sum fits SqWidth
  assign re_sq  = SqWidth'(re_i) * SqWidth'(re_i);
  assign im_sq  = SqWidth'(im_i) * SqWidth'(im_i);
  assign mag_sq = $unsigned(re_sq) + $unsigned(im_sq);

  // Hidden unless the magnitude is strictly above the threshold
  assign mag_ext    = CmpWidth'(mag_sq);
  assign thresh_ext = CmpWidth'(thresh_i);
  assign hidden_o   = (mag_ext <= thresh_ext);

endmodule

@@ src/bbo_tracker.sv @@
// Beam-order tracker and occupancy counter state.
// Uses bbo_pkg for phase codes and the result type.
module bbo_tracker #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 low_hidden_i,
  input  logic                 high_hidden_i,
  output bbo_pkg::bbo_result_t result_o
);
  import bbo_pkg::*;

  logic [PhaseWidth-1:0]          phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]         count_q, count_d;
  logic                           entry, leave, empty;
  logic [COUNT_WIDTH+OutCountWidth-1:0] count_ext;
  logic                           a, b;

  assign a = low_hidden_i;
  assign b = high_hidden_i;

  // Next phase from the order in which the beams are blocked and cleared
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_START: begin
        if (a && !b)      phase_d = PH_L0;
        else if (!a && b) phase_d = PH_R0;
      end
      PH_L0: begin
        if (!a)           phase_d = PH_START;
        else if (b)       phase_d = PH_L1;
      end
      PH_L1: begin
        if (a && !b)      phase_d = PH_L0;
        else if (!a && b) phase_d = PH_L2;
      end
      PH_L2: begin
        if (a && b)       phase_d = PH_L1;
        else if (!a && !b) phase_d = PH_L3;
      end
      PH_R0: begin
        if (!b)           phase_d = PH_START;
        else if (a)       phase_d = PH_R1;
      end
      PH_R1: begin
        if (!a && b)      phase_d = PH_R0;
        else if (a && !b) phase_d = PH_R2;
      end
      PH_R2: begin
        if (a && b)       phase_d = PH_R1;
        else if (!a && !b) phase_d = PH_R3;
      end
      default: begin
        phase_d = PH_START;
      end
    endcase
  end

  // Count entries up with saturation, exits down with an empty flag
  assign entry = (phase_d == PH_L3);
  assign leave = (phase_d == PH_R3);
  assign empty = leave && (count_q == '0);

  always_comb begin
    count_d = count_q;
    if (entry && (count_q != '1)) begin
      count_d = count_q + COUNT_WIDTH'(1);
    end else if (leave && !empty) begin
      count_d = count_q - COUNT_WIDTH'(1);
    end
  end

  // Hold state until an item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      count_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // Report the low bits of the new count
  assign count_ext = {{OutCountWidth{1'b0}}, count_d};

  always_comb begin
    result_o.occupant_count     = count_ext[OutCountWidth-1:0];
    result_o.entry_event        = entry;
    result_o.exit_event         = leave;
    result_o.empty_exit         = empty;
    result_o.low_source_hidden  = a;
    result_o.high_source_hidden = b;
    result_o.tracker_phase      = phase_d;
  end

endmodule

@@ src/bbo_checker.sv @@
// Port-level checker for the bidirectional beam occupancy counter.
// Uses bbo_pkg phase codes; bound to the top level at the end of this file.
module bbo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] occupant_count_i,
  input logic        entry_event_i,
  input logic        exit_event_i,
  input logic        empty_exit_i,
  input logic [3:0]  tracker_phase_i
);
  import bbo_pkg::*;

  // Hold a stalled result item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(occupant_count_i)
      && $stable(tracker_phase_i))
    else $error("stalled result item changed");

  // Entry flag marks exactly the end of the entry path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (entry_event_i == (tracker_phase_i == PH_L3)))
    else $error("entry flag disagrees with phase");

  // Exit flag marks exactly the end of the exit path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (exit_event_i == (tracker_phase_i == PH_R3)))
    else $error("exit flag disagrees with phase");

  // Drop below zero never: an empty exit leaves the count at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_exit_i |-> exit_event_i && (occupant_count_i == '0))
    else $error("empty exit without exit or with nonzero count");

endmodule

bind bidirectional_beam_occupancy_counter bbo_checker u_bbo_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .occupant_count_i (out_o.occupant_count),
  .entry_event_i    (out_o.entry_event),
  .exit_event_i     (out_o.exit_event),
  .empty_exit_i     (out_o.empty_exit),
  .tracker_phase_i  (out_o.tracker_phase)
);

@@ tb/bidirectional_beam_occupancy_counter_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the bidirectional beam occupancy counter: drives frames and the
// threshold register, predicts every result item and checks them in order.
// Depends on bbo_pkg, bbo_in_if, bbo_out_if and the counter RTL.
module bidirectional_beam_occupancy_counter_tb;
  import bbo_pkg::*;

  localparam logic [CountWidthDef-1:0] CountMax = '1;
  localparam int FramesPerPhase = 100;
  localparam int NumPhases      = 6;
  localparam int MaxPrinted     = 50;
  localparam int FullRateWalks  = 8;

  // Tracks the two beams and the occupancy count, holds the expected results
  class bbo_scoreboard;
    logic [ThreshWidth-1:0]   thresh;
    logic [PhaseWidth-1:0]    phase;
    logic [CountWidthDef-1:0] count;
    bbo_result_t              expected_q[$];
    int errors, frames, results, entries, exits, empty_exits, full_entries;

    function new();
      thresh       = ThreshReset;
      phase        = PH_START;
      count        = '0;
      errors       = 0;
      frames       = 0;
      results      = 0;
      entries      = 0;
      exits        = 0;
      empty_exits  = 0;
      full_entries = 0;
    endfunction

    // A source is hidden when its squared bin magnitude is at or below threshold
    function bit is_hidden(logic signed [BinWidthDef-1:0] re,
                           logic signed [BinWidthDef-1:0] im);
      logic signed [BinWidthDef:0] re_x, im_x;
      longint unsigned mag_re, mag_im;
      re_x   = re;
      im_x   = im;
      mag_re = (re_x < 0) ? -re_x : re_x;
      mag_im = (im_x < 0) ? -im_x : im_x;
      return (mag_re * mag_re + mag_im * mag_im) <= {32'd0, thresh};
    endfunction

    // Next tracker phase from the hidden flags a (low) and b (high)
    function logic [PhaseWidth-1:0] advance(logic [PhaseWidth-1:0] ph, bit a, bit b);
      case (ph)
        PH_START: begin
          if (a && !b) return PH_L0;
          if (!a && b) return PH_R0;
          return PH_START;
        end
        PH_L0: begin
          if (!a) return PH_START;
          if (b) return PH_L1;
          return PH_L0;
        end
        PH_L1: begin
          if (a && !b) return PH_L0;
          if (!a && b) return PH_L2;
          return PH_L1;
        end
        PH_L2: begin
          if (a && b) return PH_L1;
          if (!a && !b) return PH_L3;
          return PH_L2;
        end
        PH_R0: begin
          if (!b) return PH_START;
          if (a) return PH_R1;
          return PH_R0;
        end
        PH_R1: begin
          if (!a && b) return PH_R0;
          if (a && !b) return PH_R2;
          return PH_R1;
        end
        PH_R2: begin
          if (a && b) return PH_R1;
          if (!a && !b) return PH_R3;
          return PH_R2;
        end
        default: return PH_START;
      endcase
    endfunction

    // Advance the tracker for one accepted frame and queue its result
    function void note_frame(logic signed [BinWidthDef-1:0] lo_re,
                             logic signed [BinWidthDef-1:0] lo_im,
                             logic signed [BinWidthDef-1:0] hi_re,
                             logic signed [BinWidthDef-1:0] hi_im);
      bbo_result_t r;
      bit a, b;
      logic [PhaseWidth-1:0] nxt;
      a   = is_hidden(lo_re, lo_im);
      b   = is_hidden(hi_re, hi_im);
      nxt = advance(phase, a, b);
      r   = '0;
      r.entry_event = (nxt == PH_L3);
      r.exit_event  = (nxt == PH_R3);
      if (r.entry_event) begin
        entries++;
        if (count == CountMax) full_entries++;
        else count++;
      end
      if (r.exit_event) begin
        exits++;
        if (count == '0) begin
          r.empty_exit = 1'b1;
          empty_exits++;
        end else begin
          count--;
        end
      end
      phase                = nxt;
      r.occupant_count     = count[OutCountWidth-1:0];
      r.low_source_hidden  = a;
      r.high_source_hidden = b;
      r.tracker_phase      = nxt;
      expected_q.push_back(r);
      frames++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("%0t mismatch: %s", $time, msg);
    endtask

    // Compare one result item against the oldest expectation
    task check_result(bbo_result_t got);
      bbo_result_t want;
      results++;
      if (expected_q.size() == 0) begin
        report("result item with no frame pending");
      end else begin
        want = expected_q.pop_front();
        if (got.occupant_count !== want.occupant_count)
          report($sformatf("occupant_count got %0d want %0d",
                           got.occupant_count, want.occupant_count));
        if (got.entry_event !== want.entry_event)
          report($sformatf("entry_event got %b want %b", got.entry_event, want.entry_event));
        if (got.exit_event !== want.exit_event)
          report($sformatf("exit_event got %b want %b", got.exit_event, want.exit_event));
        if (got.empty_exit !== want.empty_exit)
          report($sformatf("empty_exit got %b want %b", got.empty_exit, want.empty_exit));
        if (got.low_source_hidden !== want.low_source_hidden)
          report($sformatf("low_source_hidden got %b want %b",
                           got.low_source_hidden, want.low_source_hidden));
        if (got.high_source_hidden !== want.high_source_hidden)
          report($sformatf("high_source_hidden got %b want %b",
                           got.high_source_hidden, want.high_source_hidden));
        if (got.tracker_phase !== want.tracker_phase)
          report($sformatf("tracker_phase got %0d want %0d",
                           got.tracker_phase, want.tracker_phase));
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [ThreshWidth-1:0] cfg_wdata_i;

  bbo_in_if #(.BIN_WIDTH(BinWidthDef)) in_if ();
  bbo_out_if                           out_if ();

  bbo_scoreboard sb = new();

  int stall_mode;
  int burst_left;
  bit no_gaps;
  int sent;
  int thresh_writes;

  bidirectional_beam_occupancy_counter #(
    .BIN_WIDTH  (BinWidthDef),
    .COUNT_WIDTH(CountWidthDef)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Note each accepted frame
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_frame(in_if.low_bin_real, in_if.low_bin_imag,
                    in_if.high_bin_real, in_if.high_bin_imag);
  end

  // Check each accepted result item
  always @(posedge clk_i) begin : result_mon
    bbo_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.occupant_count     = out_if.occupant_count;
      got.entry_event        = out_if.entry_event;
      got.exit_event         = out_if.exit_event;
      got.empty_exit         = out_if.empty_exit;
      got.low_source_hidden  = out_if.low_source_hidden;
      got.high_source_hidden = out_if.high_source_hidden;
      got.tracker_phase      = out_if.tracker_phase;
      sb.check_result(got);
    end
  end

  // Stall the result side: always ready, random, or a periodic pattern
  initial begin : rx_stall
    int n;
    n = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      n = (n + 1) % 11;
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(99, 0) < 60);
        default: out_if.ready <= (n >= 4) && ($urandom_range(15, 0) != 0);
      endcase
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Pick a bin that is hidden or visible under the given threshold; at 2^30 or more a visible pick is random
  function automatic void make_bin(input bit hide, input logic [ThreshWidth-1:0] thr,
                                   output logic signed [BinWidthDef-1:0] re,
                                   output logic signed [BinWidthDef-1:0] im);
    longint unsigned lim;
    int mag;
    logic signed [BinWidthDef-1:0] tmp;
    if (hide) begin
      lim = isqrt(thr >> 1);
      if (lim > 32767) lim = 32767;
      mag = $urandom_range(int'(lim), 0);
      re  = BinWidthDef'($urandom_range(1, 0) ? -mag : mag);
      mag = $urandom_range(int'(lim), 0);
      im  = BinWidthDef'($urandom_range(1, 0) ? -mag : mag);
    end else begin
      lim = isqrt(thr) + 1;
      if (lim > 32768) begin
        re = BinWidthDef'($urandom);
        im = BinWidthDef'($urandom);
      end else begin
        mag = $urandom_range(32768, int'(lim));
        re  = BinWidthDef'((mag == 32768 || $urandom_range(1, 0)) ? -mag : mag);
        im  = BinWidthDef'($urandom);
      end
    end
    if ($urandom_range(1, 0)) begin
      tmp = re;
      re  = im;
      im  = tmp;
    end
  endfunction

  // Offer one frame, idling between bursts, and hold until it is taken
  task send_frame(logic signed [BinWidthDef-1:0] lo_re, logic signed [BinWidthDef-1:0] lo_im,
                  logic signed [BinWidthDef-1:0] hi_re, logic signed [BinWidthDef-1:0] hi_im);
    if (!no_gaps && burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    end
    in_if.valid         <= 1'b1;
    in_if.low_bin_real  <= lo_re;
    in_if.low_bin_imag  <= lo_im;
    in_if.high_bin_real <= hi_re;
    in_if.high_bin_imag <= hi_im;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    sent++;
  endtask

  // Send a frame with the requested hidden flags and random content
  task send_ab(bit a, bit b);
    logic signed [BinWidthDef-1:0] lr, li, hr, hi;
    make_bin(a, sb.thresh, lr, li);
    make_bin(b, sb.thresh, hr, hi);
    send_frame(lr, li, hr, hi);
  endtask

  // Hold the sender until every expected result has come, then settle
  task drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_thresh(logic [ThreshWidth-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.thresh = v;
    thresh_writes++;
    repeat (2) @(posedge clk_i);
  endtask

  // One clean walk through the entry or exit path, then the return to start
  task walk_path(bit exit_dir);
    if (exit_dir) begin
      send_ab(1'b0, 1'b1);
      send_ab(1'b1, 1'b1);
      send_ab(1'b1, 1'b0);
    end else begin
      send_ab(1'b1, 1'b0);
      send_ab(1'b1, 1'b1);
      send_ab(1'b0, 1'b1);
    end
    send_ab(1'b0, 1'b0);
    send_ab(1'b1, 1'b1);
  endtask

  // Mostly well-formed crossings with repeats and backtracks, some noise
  task run_sequence();
    int kind, reps;
    bit [1:0] steps [4];
    bit [1:0] seq_q [$];
    kind = $urandom_range(99, 0);
    if (kind < 80) begin
      if (kind < 45) steps = '{2'b10, 2'b11, 2'b01, 2'b00};
      else steps = '{2'b01, 2'b11, 2'b10, 2'b00};
      for (int k = 0; k < 4; k++) begin
        reps = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 2) : 1;
        repeat (reps) seq_q.push_back(steps[k]);
        if ((k == 1 || k == 2) && $urandom_range(6, 0) == 0) begin
          seq_q.push_back(steps[k-1]);
          seq_q.push_back(steps[k]);
        end
      end
      seq_q.push_back(2'($urandom_range(3, 0)));
    end else if (kind < 90) begin
      repeat ($urandom_range(4, 1))
        send_frame(BinWidthDef'($urandom), BinWidthDef'($urandom),
                   BinWidthDef'($urandom), BinWidthDef'($urandom));
    end else begin
      repeat ($urandom_range(5, 1)) seq_q.push_back(2'($urandom_range(3, 0)));
    end
    foreach (seq_q[i]) send_ab(seq_q[i][1], seq_q[i][0]);
  endtask

  initial begin : main
    logic [ThreshWidth-1:0] thr_list [NumPhases];
    int start;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = ThreshReset;
    in_if.valid         = 1'b0;
    in_if.low_bin_real  = '0;
    in_if.low_bin_imag  = '0;
    in_if.high_bin_real = '0;
    in_if.high_bin_imag = '0;
    stall_mode          = 1;
    burst_left          = 0;
    no_gaps             = 1'b0;
    sent                = 0;
    thresh_writes       = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset threshold 1024^2: an entry with exact-threshold bins,
    // an exit back to zero, then an exit path that stays and never completes
    send_frame(1024, 0, -32768, -32768);
    send_frame(0, 0, 0, -1024);
    send_frame(32767, 32767, 723, 723);
    send_frame(1025, 0, 0, 1025);
    send_frame(-32768, 0, 0, 0);
    send_frame(-1025, 0, -1024, 0);
    send_frame(-1024, 0, 0, 1024);
    send_frame(0, -1024, 32767, -32768);
    send_frame(0, 32767, -32768, 1);
    send_frame(0, 0, 0, 0);
    send_frame(-32768, -32768, 0, 0);
    send_frame(1, 1, -1, -1);
    send_frame(-1, 1, 1, -1);
    send_frame(-32768, 32767, 32767, -32768);
    send_frame(0, 0, 0, 0);
    send_frame(0, 0, 0, 0);
    send_frame(32767, 0, 0, 32767);
    send_frame(724, 724, -32768, 0);
    send_frame(-32768, 5, 7, 0);
    send_frame(1025, 1025, 0, 0);
    send_frame(0, -1025, 1, 1);
    drain();

    // Random crossings over several thresholds, extremes included
    thr_list = '{32'd0, 32'h8000_0000, $urandom_range(32'h8000_0000, 0), 32'd1,
                 ThreshReset, $urandom_range(50_000_000, 2)};
    for (int p = 0; p < NumPhases; p++) begin
      write_thresh(thr_list[p]);
      stall_mode = p % 3;
      start = sent;
      while (sent - start < FramesPerPhase) run_sequence();
      drain();
    end

    // Run entries back to back at full rate, then one exit
    write_thresh(ThreshReset);
    stall_mode = 0;
    no_gaps    = 1'b1;
    repeat (FullRateWalks) walk_path(1'b0);
    walk_path(1'b1);
    no_gaps = 1'b0;
    drain();

    $display("ran %0d frames, %0d results, %0d threshold writes",
             sb.frames, sb.results, thresh_writes);
    $display("entries %0d (%0d at full count), exits %0d (%0d while empty)",
             sb.entries, sb.full_entries, sb.exits, sb.empty_exits);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("bidirectional_beam_occupancy_counter_tb: clean");
    end else begin
      $display("bidirectional_beam_occupancy_counter_tb: errors");
    end
    $finish;
  end

  // End the run if the block stops making progress
  initial begin : watchdog
    #40000000;
    $display("timeout with %0d results pending", sb.expected_q.size());
    $display("bidirectional_beam_occupancy_counter_tb: errors");
    $finish;
  end

endmodule
